// ===== design/atlbe_pkg.sv =====
// Shared types, constants and pixel helpers of the thick line blend engine.
// No dependencies; the other design files but the checker refer to it by scoped names.
`timescale 1ns / 1ps
package atlbe_pkg;

  localparam int FRAME_W = 256;
  localparam int FRAME_H = 256;
  localparam int ADDR_W  = $clog2(FRAME_W * FRAME_H);
  localparam int DIV_W   = 20;   // |dy| * 256 fits here
  localparam int DEN_W   = 12;   // dx of a folded line
  localparam int TDATA_W = 80;

  localparam logic [7:0] FULL8 = 8'hFF;

  // Configuration register indexes
  localparam logic [1:0] REG_BLEND = 2'd0;
  localparam logic [1:0] REG_OVL   = 2'd1;
  localparam logic [1:0] REG_SHINE = 2'd2;

  typedef enum logic [1:0] {
    OP_WR_OVL = 2'd0,
    OP_WR_FRM = 2'd1,
    OP_RD_FRM = 2'd2,
    OP_LINE   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [11:0] sx;
    logic signed [11:0] sy;
    logic signed [11:0] ex;
    logic signed [11:0] ey;
    logic [7:0]         level;
    logic [3:0]         half;
    logic [15:0]        color;
    logic               ok;
    logic [ADDR_W-1:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic       replace;
    logic       tint_en;
    logic [7:0] shine;
  } cfg_t;

  function automatic logic [7:0] grow5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] grow6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [15:0] join565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic pix_ok(input logic signed [13:0] x, input logic signed [13:0] y);
    return (x >= 0) && (x < FRAME_W) && (y >= 0) && (y < FRAME_H);
  endfunction

  function automatic logic [ADDR_W-1:0] pix_idx(input logic signed [13:0] x,
                                                input logic signed [13:0] y);
    return ADDR_W'(int'(y) * FRAME_W + int'(x));
  endfunction

endpackage

// ===== design/atlbe_front.sv =====
// Input side: unpack and classify stream words, queue them for the back end.
// Depends on atlbe_pkg.
`timescale 1ns / 1ps
module atlbe_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [atlbe_pkg::TDATA_W-1:0] s_axis_tdata,
  input  logic [1:0]                   s_axis_tuser,
  output logic                         cmd_valid_o,
  output atlbe_pkg::cmd_t              cmd_o,
  input  logic                         cmd_pop_i
);

  atlbe_pkg::cmd_t fifo_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  atlbe_pkg::cmd_t cmd_in;
  logic            push;
  logic signed [13:0] px, py;

  always_comb begin
    cmd_in.op    = atlbe_pkg::op_e'(s_axis_tuser);
    cmd_in.sx    = s_axis_tdata[11:0];
    cmd_in.sy    = s_axis_tdata[23:12];
    cmd_in.ex    = s_axis_tdata[35:24];
    cmd_in.ey    = s_axis_tdata[47:36];
    cmd_in.level = s_axis_tdata[55:48];
    cmd_in.half  = s_axis_tdata[60:57];
    cmd_in.color = s_axis_tdata[76:61];
    px           = {{2{s_axis_tdata[11]}}, s_axis_tdata[11:0]};
    py           = {{2{s_axis_tdata[23]}}, s_axis_tdata[23:12]};
    cmd_in.ok    = atlbe_pkg::pix_ok(px, py);
    cmd_in.idx   = cmd_in.ok ? atlbe_pkg::pix_idx(px, py) : '0;
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign cmd_o         = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule

// ===== design/atlbe_div.sv =====
// Restoring divider, one quotient bit per cycle, for the line gradient.
// Depends on atlbe_pkg.
`timescale 1ns / 1ps
module atlbe_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [atlbe_pkg::DIV_W-1:0] dividend_i,
  input  logic [atlbe_pkg::DEN_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [atlbe_pkg::DIV_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(atlbe_pkg::DIV_W);

  logic [atlbe_pkg::DEN_W-1:0] rem_q, den_q;
  logic [atlbe_pkg::DIV_W-1:0] quo_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        busy_q, done_q;
  logic [atlbe_pkg::DEN_W:0]   trial;
  logic                        fits;

  assign trial = {rem_q, quo_q[atlbe_pkg::DIV_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? atlbe_pkg::DEN_W'(trial - {1'b0, den_q})
                    : trial[atlbe_pkg::DEN_W-1:0];
      quo_q <= {quo_q[atlbe_pkg::DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(atlbe_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/atlbe_back.sv =====
// Back end: pixel store access, line stepping and blend read-modify-write.
// Depends on atlbe_pkg and atlbe_div.
`timescale 1ns / 1ps
module atlbe_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  atlbe_pkg::cfg_t   cfg_i,
  input  logic              cmd_valid_i,
  input  atlbe_pkg::cmd_t   cmd_i,
  output logic              cmd_pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,
  output logic              m_axis_tuser
);

  localparam int AW = atlbe_pkg::ADDR_W;
  localparam int DEPTH = atlbe_pkg::FRAME_W * atlbe_pkg::FRAME_H;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_PRD   = 11'b00000000010,
    S_SETUP = 11'b00000000100,
    S_DIV   = 11'b00000001000,
    S_COL   = 11'b00000010000,
    S_PLOT  = 11'b00000100000,
    S_TINT  = 11'b00001000000,
    S_BEAM  = 11'b00010000000,
    S_WR    = 11'b00100000000,
    S_NEXT  = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] frm_mem [DEPTH];
  logic [15:0] ovl_mem [DEPTH];
  logic [15:0] frm_rd_q, ovl_rd_q;
  logic        frm_we, frm_re, ovl_we, ovl_re;
  logic [AW-1:0] frm_waddr, rd_addr;
  logic [15:0] frm_wdata;

  atlbe_pkg::cmd_t cmd_q;
  logic               steep_q, dot_q, neg_q, fin_q;
  logic signed [13:0] maj_q, end_q, yi_q;
  logic signed [20:0] minor_q;
  logic signed [9:0]  slope_q;
  logic [4:0]         k_q, kmax_q;
  logic [7:0]         at_q, ab_q, alpha_q;
  logic [AW-1:0]      addr_q;
  logic [7:0]         tch_q [3];
  logic [15:0]        beam_q;

  logic        out_valid_q, out_user_q;
  logic [15:0] out_data_q;
  logic        out_load;

  // setup datapath
  logic signed [12:0] ax, ay, bx, by, adx, ady, p0, q0, p1, q1, m0, n0, m1, n1, dx, dy;
  logic [11:0]        dy_abs;
  logic               steep, swap, div_start, div_done;
  logic [atlbe_pkg::DIV_W-1:0] quo;
  logic signed [13:0] half_s;

  // column and pixel datapath
  logic [7:0]         frac;
  logic [15:0]        prod_top, prod_bot;
  logic signed [13:0] cpos, px, py;
  logic               pok;
  logic [AW-1:0]      pidx;
  logic [7:0]         palpha;
  logic [7:0]         ov_ch [3];
  logic [7:0]         tch [3];
  logic [15:0]        tmul [3];
  logic [16:0]        tsum [3];
  logic [15:0]        bmul [3];
  logic [7:0]         bch [3];
  logic [7:0]         fch [3];
  logic [7:0]         sch [3];
  logic [8:0]         asum [3];
  logic [7:0]         rch [3];

  always_comb begin
    ax  = 13'(cmd_q.sx);
    ay  = 13'(cmd_q.sy);
    bx  = 13'(cmd_q.ex);
    by  = 13'(cmd_q.ey);
    adx = (bx > ax) ? bx - ax : ax - bx;
    ady = (by > ay) ? by - ay : ay - by;
    steep = (ady > adx);
    p0 = steep ? ay : ax;
    q0 = steep ? ax : ay;
    p1 = steep ? by : bx;
    q1 = steep ? bx : by;
    swap = (p0 > p1);
    m0 = swap ? p1 : p0;
    n0 = swap ? q1 : q0;
    m1 = swap ? p0 : p1;
    n1 = swap ? q0 : q1;
    dx = m1 - m0;
    dy = n1 - n0;
    dy_abs = dy[12] ? 12'(-dy) : dy[11:0];
    half_s = $signed({10'b0, cmd_q.half});
  end

  assign div_start = (state_q == S_SETUP) && (dx != 13'sd0);

  atlbe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({dy_abs, 8'b0}),
    .divisor_i  (dx[11:0]),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    frac     = minor_q[7:0];
    prod_top = cmd_q.level * (atlbe_pkg::FULL8 - frac);
    prod_bot = cmd_q.level * frac;
    cpos     = yi_q - half_s + $signed({9'b0, k_q});
    px       = steep_q ? cpos : maj_q;
    py       = steep_q ? maj_q : cpos;
    pok      = atlbe_pkg::pix_ok(px, py);
    pidx     = atlbe_pkg::pix_idx(px, py);
    if (k_q == 5'd0) palpha = at_q;
    else if (k_q == {cmd_q.half, 1'b1}) palpha = ab_q;
    else palpha = cmd_q.level;
  end

  // beam and blend arithmetic, one channel per lane
  always_comb begin
    ov_ch[0] = atlbe_pkg::grow5(ovl_rd_q[15:11]);
    ov_ch[1] = atlbe_pkg::grow6(ovl_rd_q[10:5]);
    ov_ch[2] = atlbe_pkg::grow5(ovl_rd_q[4:0]);
    fch[0]   = atlbe_pkg::grow5(frm_rd_q[15:11]);
    fch[1]   = atlbe_pkg::grow6(frm_rd_q[10:5]);
    fch[2]   = atlbe_pkg::grow5(frm_rd_q[4:0]);
    sch[0]   = atlbe_pkg::grow5(beam_q[15:11]);
    sch[1]   = atlbe_pkg::grow6(beam_q[10:5]);
    sch[2]   = atlbe_pkg::grow5(beam_q[4:0]);
    for (int i = 0; i < 3; i++) begin
      tmul[i] = (atlbe_pkg::FULL8 - ov_ch[i]) * cfg_i.shine;
      tsum[i] = {1'b0, tmul[i]} + 17'(atlbe_pkg::FULL8);
      tch[i]  = (cfg_i.tint_en && (cfg_i.shine != 8'd0))
                ? atlbe_pkg::FULL8 - tsum[i][15:8] : atlbe_pkg::FULL8;
      bmul[i] = tch_q[i] * alpha_q;
      bch[i]  = bmul[i][15:8];
      asum[i] = {1'b0, fch[i]} + {1'b0, sch[i]};
      rch[i]  = asum[i][8] ? atlbe_pkg::FULL8 : asum[i][7:0];
    end
  end

  // store ports
  always_comb begin
    cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
    frm_we    = 1'b0;
    ovl_we    = 1'b0;
    frm_re    = 1'b0;
    ovl_re    = 1'b0;
    frm_waddr = cmd_i.idx;
    frm_wdata = cmd_i.color;
    rd_addr   = cmd_i.idx;
    if (cmd_pop_o) begin
      ovl_we = cmd_i.ok && (cmd_i.op == atlbe_pkg::OP_WR_OVL);
      frm_we = cmd_i.ok && (cmd_i.op == atlbe_pkg::OP_WR_FRM);
      frm_re = cmd_i.ok && (cmd_i.op == atlbe_pkg::OP_RD_FRM);
    end
    if (state_q == S_PLOT) begin
      rd_addr = pidx;
      frm_re  = pok;
      ovl_re  = pok;
    end
    if (state_q == S_WR) begin
      frm_we    = 1'b1;
      frm_waddr = addr_q;
      frm_wdata = cfg_i.replace ? beam_q : atlbe_pkg::join565(rch[0], rch[1], rch[2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (frm_we) frm_mem[frm_waddr] <= frm_wdata;
    if (frm_re) frm_rd_q <= frm_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ovl_we) ovl_mem[cmd_i.idx] <= cmd_i.color;
    if (ovl_re) ovl_rd_q <= ovl_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == atlbe_pkg::OP_RD_FRM) state_d = S_PRD;
          else if (cmd_i.op == atlbe_pkg::OP_LINE) state_d = S_SETUP;
        end
      end
      S_PRD:   state_d = S_EMIT;
      S_SETUP: state_d = (dx == 13'sd0) ? S_COL : S_DIV;
      S_DIV:   if (div_done) state_d = S_COL;
      S_COL:   state_d = S_PLOT;
      S_PLOT:  state_d = pok ? S_TINT : S_NEXT;
      S_TINT:  state_d = S_BEAM;
      S_BEAM:  state_d = S_WR;
      S_WR:    state_d = S_NEXT;
      S_NEXT: begin
        if (k_q != kmax_q) state_d = S_PLOT;
        else if (maj_q == end_q) state_d = S_EMIT;
        else state_d = S_COL;
      end
      S_EMIT:  if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q <= cmd_i;
        fin_q <= (cmd_i.op == atlbe_pkg::OP_LINE);
      end
      S_SETUP: begin
        steep_q <= steep;
        neg_q   <= dy[12];
        minor_q <= {n0, 8'b0};
        if (dx == 13'sd0) begin
          dot_q   <= 1'b1;
          maj_q   <= 14'(m0) - half_s;
          end_q   <= 14'(m0) + half_s;
          slope_q <= '0;
        end else begin
          dot_q <= 1'b0;
          maj_q <= 14'(m0);
          end_q <= 14'(m1);
        end
      end
      S_DIV: begin
        if (div_done) slope_q <= neg_q ? -$signed({1'b0, quo[8:0]}) : $signed({1'b0, quo[8:0]});
      end
      S_COL: begin
        yi_q   <= 14'($signed(minor_q[20:8]));
        at_q   <= dot_q ? cmd_q.level : prod_top[15:8];
        ab_q   <= prod_bot[15:8];
        kmax_q <= {cmd_q.half, 1'b0} + 5'(frac != 8'd0);
        k_q    <= '0;
      end
      S_PLOT: begin
        alpha_q <= palpha;
        addr_q  <= pidx;
      end
      S_TINT: begin
        for (int i = 0; i < 3; i++) tch_q[i] <= tch[i];
      end
      S_BEAM: begin
        beam_q <= atlbe_pkg::join565(bch[0], bch[1], bch[2]);
      end
      S_NEXT: begin
        if (k_q != kmax_q) begin
          k_q <= k_q + 5'd1;
        end else begin
          maj_q   <= maj_q + 14'sd1;
          minor_q <= minor_q + 21'(slope_q);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_user_q <= fin_q;
      out_data_q <= (!fin_q && cmd_q.ok) ? frm_rd_q : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== design/aa_thick_line_blend_engine_core.sv =====
// Top level of the antialiased thick line blend engine: configuration
// registers, input front end and back end. Depends on atlbe_pkg, atlbe_front, atlbe_back.
//
//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | tdata: command fields, tuser: op
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata: read_color, tuser: done
//  cfg      | in  | cfg_we_i (always taken)        | cfg_index_i, cfg_data_i
//
// A pixel write retires as it is popped; a frame read passes the pop, S_PRD and S_EMIT,
// then waits for output. A line passes the pop, S_SETUP, the gradient divider (skipped
// for a dot), then per major step S_COL and per drawn pixel S_PLOT, S_TINT, S_BEAM, S_WR
// and S_NEXT (only S_PLOT and S_NEXT if clipped), and S_EMIT to load the result.
// Reset clears control state only; store contents are undefined until written.
// A 2-word queue lets the input side keep taking words while the back end is
// busy or a result waits in the output register for m_axis_tready.
`timescale 1ns / 1ps
module aa_thick_line_blend_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] start_x, [23:12] start_y, [35:24] end_x, [47:36] end_y,
  // [55:48] beam_level, [60:56] line_width, [76:61] pixel_color, rest zero
  input  logic [79:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] read_color
  output logic        m_axis_tuser,   // [0] line_finished
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  atlbe_pkg::cfg_t cfg_q;
  atlbe_pkg::cmd_t cmd;
  logic            cmd_valid, cmd_pop;

  // Hold configuration; write it only while the engine is idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        atlbe_pkg::REG_BLEND: cfg_q.replace <= cfg_data_i[0];
        atlbe_pkg::REG_OVL:   cfg_q.tint_en <= cfg_data_i[0];
        atlbe_pkg::REG_SHINE: cfg_q.shine   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack, classify and queue incoming words.
  atlbe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // Execute commands against the stores and drive the result register.
  atlbe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== design/atlbe_checker.sv =====
// Port-level checks for the thick line blend engine, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
module atlbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result word keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // A line completion word carries no colour.
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("line completion word with nonzero color");

  // No result is pending right after reset release.
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind aa_thick_line_blend_engine_core atlbe_checker u_atlbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/tb_aa_thick_line_blend_engine_core.sv =====
// Self-checking bench for the antialiased thick line blend engine: drives command
// words, predicts frame reads and line completions, checks every result word.
// Depends on atlbe_pkg and aa_thick_line_blend_engine_core.
`timescale 1ns / 1ps
module tb_aa_thick_line_blend_engine_core;

  localparam int FW         = atlbe_pkg::FRAME_W;
  localparam int FH         = atlbe_pkg::FRAME_H;
  localparam int WIN        = 16;      // corner window of both stores, filled first
  localparam int IDLE_LIMIT = 200000;  // cycles with no word moving on either side
  localparam int TAIL       = 40;      // settle time after the last result

  typedef struct {
    atlbe_pkg::op_e     op;
    logic signed [11:0] sx, sy, ex, ey;
    logic [7:0]         level;
    logic [4:0]         wid;
    logic [15:0]        color;
  } tb_cmd_t;

  typedef struct {
    logic [15:0] color;
    logic        done;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  aa_thick_line_blend_engine_core u_top (.*);

  always #2 clk_i = ~clk_i;

  // Shadow copy of the block's stores and registers
  logic [15:0] frame_mem [FW*FH];
  logic [15:0] tint_mem [FW*FH];
  logic        replace_on;
  logic        tint_on;
  logic [7:0]  shine_lvl;

  reply_t reply_q[$];
  int     errors;
  bit     send_gaps, recv_gaps;
  int     hold_left, stall_left, quiet_cycles;

  task automatic report(string what, int got, int exp_v);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_v, $realtime);
    errors++;
  endtask

  // ---------------- predictor ----------------
  function automatic int expand(int v, int bits);
    return bits == 5 ? (v << 3) | (v >> 2) : (v << 2) | (v >> 4);
  endfunction

  function automatic void unpack(logic [15:0] c, output int ch[3]);
    ch[0] = expand(int'(c[15:11]), 5);
    ch[1] = expand(int'(c[10:5]), 6);
    ch[2] = expand(int'(c[4:0]), 5);
  endfunction

  function automatic logic [15:0] pack(int ch[3]);
    logic [7:0] r, g, b;
    r = 8'(ch[0]); g = 8'(ch[1]); b = 8'(ch[2]);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [15:0] beam_rgb(int idx, int alpha);
    int ch[3];
    if (tint_on && shine_lvl != 0) begin
      unpack(tint_mem[idx], ch);
      for (int i = 0; i < 3; i++)
        ch[i] = 255 - ((((255 - ch[i]) * int'(shine_lvl)) + 255) >> 8);
    end else begin
      ch = '{255, 255, 255};
    end
    for (int i = 0; i < 3; i++) ch[i] = (ch[i] * alpha) >> 8;
    return pack(ch);
  endfunction

  function automatic void blend_pixel(int x, int y, int alpha);
    int idx;
    int f[3], b[3];
    if (x < 0 || x >= FW || y < 0 || y >= FH) return;
    idx = y * FW + x;
    if (replace_on) begin
      frame_mem[idx] = beam_rgb(idx, alpha);
      return;
    end
    unpack(frame_mem[idx], f);
    unpack(beam_rgb(idx, alpha), b);
    for (int i = 0; i < 3; i++) f[i] = (f[i] + b[i] > 255) ? 255 : f[i] + b[i];
    frame_mem[idx] = pack(f);
  endfunction

  function automatic void put(bit steep, int major, int minor, int alpha);
    if (steep) blend_pixel(minor, major, alpha);
    else blend_pixel(major, minor, alpha);
  endfunction

  function automatic void render_line(int x0, int y0, int x1, int y1, int level, int half);
    int adx, ady, t, dx, dy, slope, minor, frac, yi;
    bit steep;
    adx = x1 > x0 ? x1 - x0 : x0 - x1;
    ady = y1 > y0 ? y1 - y0 : y0 - y1;
    steep = ady > adx;
    if (steep) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx = x1 - x0;
    dy = y1 - y0;
    if (dx == 0) begin
      // zero length: square dot at full level
      for (int oy = -half; oy <= half; oy++)
        for (int ox = -half; ox <= half; ox++) put(steep, x0 + ox, y0 + oy, level);
      return;
    end
    slope = (dy * 256) / dx;   // truncates toward zero
    minor = y0 * 256;
    for (int maj = x0; maj <= x1; maj++) begin
      frac = minor & 255;
      yi = (minor - frac) / 256;
      put(steep, maj, yi - half, (level * (255 - frac)) >> 8);
      for (int c = yi - half + 1; c <= yi + half; c++) put(steep, maj, c, level);
      if (frac != 0) put(steep, maj, yi + half + 1, (level * frac) >> 8);
      minor += slope;
    end
  endfunction

  function automatic void predict(tb_cmd_t c);
    bit ok;
    int idx;
    ok = c.sx >= 0 && c.sx < FW && c.sy >= 0 && c.sy < FH;
    idx = ok ? int'(c.sy) * FW + int'(c.sx) : 0;
    case (c.op)
      atlbe_pkg::OP_WR_OVL: if (ok) tint_mem[idx] = c.color;
      atlbe_pkg::OP_WR_FRM: if (ok) frame_mem[idx] = c.color;
      atlbe_pkg::OP_RD_FRM: reply_q.push_back('{ok ? frame_mem[idx] : 16'h0, 1'b0});
      default: begin
        render_line(int'(c.sx), int'(c.sy), int'(c.ex), int'(c.ey), int'(c.level),
                    int'(c.wid >> 1));
        reply_q.push_back('{16'h0, 1'b1});
      end
    endcase
  endfunction

  // ---------------- drivers ----------------
  task automatic send_cmd(tb_cmd_t c);
    int n;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      n = int'($urandom_range(1, 15));
      repeat (n) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.op;
    s_axis_tdata  <= {3'b0, c.color, c.wid, c.level, c.ey, c.ex, c.sy, c.sx};
    do @(posedge clk_i); while (!s_axis_tready);
    predict(c);
  endtask

  function automatic tb_cmd_t pixel_cmd(atlbe_pkg::op_e op, int x, int y, logic [15:0] color);
    tb_cmd_t c;
    c.op    = op;
    c.sx    = 12'(x);
    c.sy    = 12'(y);
    c.ex    = 12'($urandom);
    c.ey    = 12'($urandom);
    c.level = 8'($urandom);
    c.wid   = 5'($urandom);
    c.color = color;
    return c;
  endfunction

  function automatic tb_cmd_t line_cmd(int x0, int y0, int x1, int y1, int level, int wid);
    tb_cmd_t c;
    c.op    = atlbe_pkg::OP_LINE;
    c.sx    = 12'(x0);
    c.sy    = 12'(y0);
    c.ex    = 12'(x1);
    c.ey    = 12'(y1);
    c.level = 8'(level);
    c.wid   = 5'(wid);
    c.color = 16'($urandom);
    return c;
  endfunction

  // drop valid, drain all expected words, then let queued writes retire
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      atlbe_pkg::REG_BLEND: replace_on = val[0];
      atlbe_pkg::REG_OVL:   tint_on    = val[0];
      default:              shine_lvl  = val;
    endcase
  endtask

  task automatic set_mode(bit rep, bit tint, logic [7:0] shine);
    write_reg(atlbe_pkg::REG_BLEND, 8'(rep));
    write_reg(atlbe_pkg::REG_OVL, 8'(tint));
    write_reg(atlbe_pkg::REG_SHINE, shine);
  endtask

  // receiver: long hold on request, else random stall bursts
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
      stall_left = int'($urandom_range(1, 15)) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    reply_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (reply_q.size() == 0) begin
        report("unexpected word", int'(m_axis_tdata), 0);
      end else begin
        want = reply_q.pop_front();
        if (m_axis_tdata !== want.color)
          report("read_color", int'(m_axis_tdata), int'(want.color));
        if (m_axis_tuser !== want.done)
          report("line_finished", int'(m_axis_tuser), int'(want.done));
      end
    end
  end

  // watchdog: count cycles where neither side moves a word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else if (rst_ni)
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------- tests ----------------
  // write the corner window of both stores; later reads stay inside it,
  // off the frame, or on pixels that a write or an untinted replace pass has set
  task automatic test_fill();
    for (int y = 0; y < WIN; y++)
      for (int x = 0; x < WIN; x++) begin
        send_cmd(pixel_cmd(atlbe_pkg::OP_WR_OVL, x, y, 16'($urandom)));
        send_cmd(pixel_cmd(atlbe_pkg::OP_WR_FRM, x, y, 16'($urandom)));
      end
    drain();
  endtask

  task automatic test_pixel_ops();
    send_cmd(pixel_cmd(atlbe_pkg::OP_WR_FRM, 0, 0, 16'h0000));
    send_cmd(pixel_cmd(atlbe_pkg::OP_WR_FRM, 255, 255, 16'hFFFF));
    send_cmd(pixel_cmd(atlbe_pkg::OP_WR_OVL, 255, 0, 16'hFFFF));
    send_cmd(pixel_cmd(atlbe_pkg::OP_WR_FRM, -2048, 2047, 16'h1234));   // clipped, ignored
    send_cmd(pixel_cmd(atlbe_pkg::OP_WR_OVL, 2047, -2048, 16'h4321));
    send_cmd(pixel_cmd(atlbe_pkg::OP_RD_FRM, 0, 0, 16'h0));
    send_cmd(pixel_cmd(atlbe_pkg::OP_RD_FRM, 255, 255, 16'h0));
    send_cmd(pixel_cmd(atlbe_pkg::OP_RD_FRM, -1, 10, 16'h0));           // outside: zero reply
    send_cmd(pixel_cmd(atlbe_pkg::OP_RD_FRM, 256, 2047, 16'h0));
    send_cmd(pixel_cmd(atlbe_pkg::OP_RD_FRM, -2048, -2048, 16'h0));
    drain();
  endtask

  // window lines touch only the filled corner; wide lines cross the frame
  // and are first drawn in untinted replace mode
  task automatic test_lines_directed(bit wide);
    send_cmd(line_cmd(1, 1, 12, 5, 255, 3));          // shallow
    send_cmd(line_cmd(10, 13, 8, 1, 200, 2));         // steep, reversed
    send_cmd(line_cmd(12, 12, 2, 9, 128, 0));         // shallow, reversed
    send_cmd(line_cmd(2, 12, 12, 2, 255, 1));         // diagonal, negative slope
    send_cmd(line_cmd(7, 0, 7, 13, 90, 2));           // vertical
    send_cmd(line_cmd(0, 8, 14, 8, 0, 0));            // horizontal, zero level
    send_cmd(line_cmd(7, 7, 7, 7, 255, 14));          // dot
    send_cmd(line_cmd(3, 3, 3, 3, 77, 0));            // single pixel dot
    send_cmd(line_cmd(0, 0, 0, 0, 255, 30));          // dot clipped at corner
    send_cmd(line_cmd(-10, -5, 5, 9, 255, 4));        // enters from off the frame
    send_cmd(line_cmd(-2048, -2048, -1000, -1500, 255, 0));  // fully clipped
    send_cmd(line_cmd(-5, 14, 14, -5, 64, 1));
    if (wide) begin
      send_cmd(line_cmd(250, 240, 270, 262, 255, 6));  // runs off the frame
      send_cmd(line_cmd(-2048, -2048, 2047, 2047, 255, 0));
      send_cmd(line_cmd(2047, -2048, -2048, 2047, 64, 1));
      send_cmd(line_cmd(40, 60, 33, 20, 200, 4));
      send_cmd(line_cmd(100, 100, 60, 90, 128, 0));
      send_cmd(line_cmd(128, 128, 128, 128, 255, 31)); // dot, widest
    end
    drain();
  endtask

  task automatic test_back_pressure();
    hold_left = 500;   // receiver holds off while reads keep coming
    for (int i = 0; i < 12; i++)
      send_cmd(pixel_cmd(atlbe_pkg::OP_RD_FRM, int'($urandom_range(0, WIN - 1)),
                         int'($urandom_range(0, WIN - 1)), 16'h0));
    drain();
  endtask

  function automatic int clamp_to(int v, int hi);
    return v > hi ? hi : (v < -2048 ? -2048 : v);
  endfunction

  // mostly near the filled window, sometimes far off the frame
  function automatic int near_coord(int hi);
    if ($urandom_range(0, 9) == 0) return -int'($urandom_range(1, 2048));
    return int'($urandom_range(0, hi + 24)) - 24;
  endfunction

  task automatic test_random(int count);
    tb_cmd_t c;
    int pick, x, y, wid, hi;
    for (int i = 0; i < count; i++) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 50) begin
        x = near_coord(WIN - 1);
        y = near_coord(WIN - 1);
        if (pick < 15) c = pixel_cmd(atlbe_pkg::OP_WR_OVL, x, y, 16'($urandom));
        else if (pick < 30) c = pixel_cmd(atlbe_pkg::OP_WR_FRM, x, y, 16'($urandom));
        else c = pixel_cmd(atlbe_pkg::OP_RD_FRM, x, y, 16'h0);
      end else begin
        wid = $urandom_range(0, 9) == 0 ? int'($urandom_range(0, 31))
                                        : int'($urandom_range(0, 7));
        hi = WIN - 2 - (wid >> 1);
        x = near_coord(hi);
        y = near_coord(hi);
        c = line_cmd(x, y, clamp_to(x + int'($urandom_range(0, 40)) - 20, hi),
                     clamp_to(y + int'($urandom_range(0, 40)) - 20, hi),
                     int'($urandom_range(0, 255)), wid);
      end
      send_cmd(c);
    end
    drain();
  endtask

  initial begin
    errors = 0;
    hold_left = 0;
    stall_left = 0;
    quiet_cycles = 0;
    replace_on = 1'b0;
    tint_on = 1'b0;
    shine_lvl = 8'd0;
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_fill();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    test_pixel_ops();
    set_mode(1'b1, 1'b0, 8'd0);
    test_lines_directed(1'b1);
    set_mode(1'b0, 1'b0, 8'd0);
    test_lines_directed(1'b1);
    set_mode(1'b0, 1'b1, 8'd255);
    test_lines_directed(1'b0);
    set_mode(1'b1, 1'b1, 8'd0);       // tint enabled but zero weight: white
    test_lines_directed(1'b1);
    set_mode(1'b1, 1'b1, 8'd128);
    test_lines_directed(1'b0);
    test_back_pressure();

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end
      set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               8'($urandom_range(0, 255)));
      test_random(85);
    end

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
